// ===== src/sfs_pkg.sv =====
package sfs_pkg;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_SET     = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [3:0] MODE_STOP       = 4'd0;
	localparam logic [3:0] MODE_LOOP       = 4'd1;
	localparam logic [3:0] MODE_ONCE_DIE   = 4'd2;
	localparam logic [3:0] MODE_ONCE_FIRST = 4'd3;
	localparam logic [3:0] MODE_ONCE_LAST  = 4'd4;
	localparam logic [3:0] MODE_BACK_ONCE  = 4'd5;
	localparam logic [3:0] MODE_PING_FWD   = 4'd6;
	localparam logic [3:0] MODE_PING_BACK  = 4'd7;
	localparam logic [3:0] MODE_LOOP_BACK  = 4'd8;
	localparam logic [3:0] MODE_TOGGLE     = 4'd9;
	localparam logic [3:0] MODE_RANDOM     = 4'd10;

	typedef struct packed {
		logic [1:0] operation;
		logic       hold;
		logic [3:0] new_mode;
		logic [7:0] new_speed;
		logic [7:0] random_frame;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_index;
		logic [3:0] mode;
		logic       expired;
		logic       stepped;
	} out_item_t;

	typedef struct packed {
		logic [7:0] frame;
		logic [7:0] timer;
		logic [3:0] mode;
		logic [7:0] speed;
		logic       expired;
	} seq_state_t;

endpackage

// ===== src/sfs_if.sv =====
interface sfs_in_if import sfs_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sfs_out_if import sfs_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/sprite_frame_sequencer.sv =====
// Sprite animation frame sequencer.
// Channels: req carries one command item (tick, set mode and speed, restart);
// rsp returns one item per command with the frame, mode, expired flag and
// whether this tick stepped the frame. cfg_we/cfg_wdata load frame_count;
// write it only while no item is in flight.
// Pipeline: an item accepted from req is registered in the input register,
// processed by the next-state logic, and its result is registered in the
// result register that drives rsp.
// Throughput: one item per cycle unless the receiver stalls; the state
// registers update in the same cycle that the item leaves the input
// register, so each item sees the state its predecessor left.
// Reset: frame 0, timer 0, mode 1 (loop), speed 0, not expired,
// frame_count 1, both pipeline registers empty.
// Receiver stall: the result register holds its item, the input register
// holds the next one, and req.ready drops once both are occupied.
module sprite_frame_sequencer import sfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sfs_in_if.sink      req,
	sfs_out_if.source   rsp,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	logic       v_s1;
	in_item_t   item_s1;
	logic       adv_s1;
	logic [7:0] frame_count_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	logic       stepped_nxt;
	logic       rsp_valid_q;
	out_item_t  rsp_data_q;

	assign adv_s1 = v_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !v_s1 || adv_s1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_data_q;

	sfs_step u_step (
		.cur         (state_q),
		.item        (item_s1),
		.frame_count (frame_count_q),
		.nxt         (state_nxt),
		.stepped     (stepped_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= 8'd1;
		end else if (cfg_we) begin
			frame_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{frame: 8'd0, timer: 8'd0, mode: MODE_LOOP, speed: 8'd0,
				expired: 1'b0};
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (!rsp_valid_q || rsp.ready) begin
			rsp_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_data_q <= '{frame_index: state_nxt.frame, mode: state_nxt.mode,
				expired: state_nxt.expired, stepped: stepped_nxt};
		end
	end

	a_expired_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.expired |=> state_q.expired)
		else $error("expired flag cleared");

	a_expired_frame_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.expired |=> $stable(state_q.frame))
		else $error("frame changed after expiry");

	a_timer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.timer <= state_q.speed)
		else $error("tick timer beyond speed");

	a_state_only_on_item: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("state changed without an item");

endmodule

// ===== src/sfs_step.sv =====
module sfs_step import sfs_pkg::*; (
	input  seq_state_t cur,
	input  in_item_t   item,
	input  logic [7:0] frame_count,
	output seq_state_t nxt,
	output logic       stepped
);

	logic [7:0] last;
	logic [7:0] f;
	logic       active;

	always_comb begin
		last = (frame_count == 8'd0) ? 8'd0 : frame_count - 8'd1;
		f = cur.frame;
		if (cur.mode != MODE_TOGGLE && cur.mode != MODE_RANDOM && f > last) begin
			f = last;
		end
		active = (cur.mode != MODE_STOP) && (cur.mode <= MODE_RANDOM) && !item.hold
			&& !cur.expired;
		nxt = cur;
		stepped = 1'b0;
		case (item.operation)
			OP_TICK: begin
				if (active) begin
					if (cur.timer != cur.speed) begin
						nxt.timer = cur.timer + 8'd1;
					end else begin
						nxt.timer = 8'd0;
						stepped = 1'b1;
						nxt.frame = f;
						case (cur.mode)
							MODE_LOOP: begin
								nxt.frame = (f >= last) ? 8'd0 : f + 8'd1;
							end
							MODE_ONCE_DIE: begin
								if (f < last) begin
									nxt.frame = f + 8'd1;
								end
								if (f + 8'd1 >= last || f == last) begin
									nxt.expired = 1'b1;
								end
							end
							MODE_ONCE_FIRST, MODE_ONCE_LAST: begin
								if (f >= last) begin
									nxt.frame = (cur.mode == MODE_ONCE_LAST) ? last : 8'd0;
									nxt.mode = MODE_STOP;
								end else begin
									nxt.frame = f + 8'd1;
								end
							end
							MODE_BACK_ONCE: begin
								if (f == 8'd0) begin
									nxt.mode = MODE_STOP;
								end else begin
									nxt.frame = f - 8'd1;
								end
							end
							MODE_PING_FWD: begin
								if (f >= last) begin
									nxt.frame = (last >= 8'd1) ? last - 8'd1 : 8'd0;
									nxt.mode = MODE_PING_BACK;
								end else begin
									nxt.frame = f + 8'd1;
								end
							end
							MODE_PING_BACK: begin
								if (f == 8'd0) begin
									nxt.frame = (last >= 8'd1) ? 8'd1 : 8'd0;
									nxt.mode = MODE_PING_FWD;
								end else begin
									nxt.frame = f - 8'd1;
								end
							end
							MODE_LOOP_BACK: begin
								nxt.frame = (f == 8'd0) ? last : f - 8'd1;
							end
							MODE_TOGGLE: begin
								nxt.frame = (f == 8'd0) ? 8'd1 : 8'd0;
							end
							MODE_RANDOM: begin
								nxt.frame = (item.random_frame > last) ? last : item.random_frame;
							end
							default: begin
								nxt.frame = f;
							end
						endcase
					end
				end
			end
			OP_SET: begin
				nxt.mode = item.new_mode;
				nxt.speed = item.new_speed;
				nxt.timer = 8'd0;
				if ((item.new_mode == MODE_BACK_ONCE || item.new_mode == MODE_LOOP_BACK)
					&& !cur.expired) begin
					nxt.frame = last;
				end
			end
			OP_RESTART: begin
				nxt.timer = 8'd0;
				if (!cur.expired) begin
					nxt.frame = 8'd0;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== dv/sprite_frame_sequencer_tb.sv =====
`timescale 1ns / 1ps

module sprite_frame_sequencer_tb;
	import sfs_pkg::*;

	class frame_scoreboard;
		seq_state_t  st;
		logic [7:0]  frame_count;
		out_item_t   pending[$];
		int          errors;

		function new();
			st.frame    = 8'd0;
			st.timer    = 8'd0;
			st.mode     = MODE_LOOP;
			st.speed    = 8'd0;
			st.expired  = 1'b0;
			frame_count = 8'd1;
			errors      = 0;
		endfunction

		task report(input string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function out_item_t predict(input in_item_t it);
			logic [7:0] last;
			logic [7:0] f;
			out_item_t  res;
			last = (frame_count == 8'd0) ? 8'd0 : frame_count - 8'd1;
			res.stepped = 1'b0;
			case (it.operation)
				OP_TICK: begin
					if (st.mode != MODE_STOP && st.mode <= MODE_RANDOM && !it.hold && !st.expired) begin
						if (st.timer != st.speed) begin
							st.timer = st.timer + 8'd1;
						end else begin
							st.timer = 8'd0;
							res.stepped = 1'b1;
							f = st.frame;
							if (st.mode != MODE_TOGGLE && st.mode != MODE_RANDOM && f > last)
								f = last;
							case (st.mode)
								MODE_LOOP: f = (f >= last) ? 8'd0 : f + 8'd1;
								MODE_ONCE_DIE: begin
									if (f < last)
										f = f + 8'd1;
									if (f == last)
										st.expired = 1'b1;
								end
								MODE_ONCE_FIRST, MODE_ONCE_LAST: begin
									if (f >= last) begin
										f = (st.mode == MODE_ONCE_LAST) ? last : 8'd0;
										st.mode = MODE_STOP;
									end else begin
										f = f + 8'd1;
									end
								end
								MODE_BACK_ONCE: begin
									if (f == 8'd0)
										st.mode = MODE_STOP;
									else
										f = f - 8'd1;
								end
								MODE_PING_FWD: begin
									if (f >= last) begin
										f = (last >= 8'd1) ? last - 8'd1 : 8'd0;
										st.mode = MODE_PING_BACK;
									end else begin
										f = f + 8'd1;
									end
								end
								MODE_PING_BACK: begin
									if (f == 8'd0) begin
										f = (last >= 8'd1) ? 8'd1 : 8'd0;
										st.mode = MODE_PING_FWD;
									end else begin
										f = f - 8'd1;
									end
								end
								MODE_LOOP_BACK: f = (f == 8'd0) ? last : f - 8'd1;
								MODE_TOGGLE: f = (f == 8'd0) ? 8'd1 : 8'd0;
								MODE_RANDOM: f = (it.random_frame > last) ? last : it.random_frame;
								default: ;
							endcase
							st.frame = f;
						end
					end
				end
				OP_SET: begin
					st.mode  = it.new_mode;
					st.speed = it.new_speed;
					st.timer = 8'd0;
					if ((it.new_mode == MODE_BACK_ONCE || it.new_mode == MODE_LOOP_BACK) && !st.expired)
						st.frame = last;
				end
				OP_RESTART: begin
					st.timer = 8'd0;
					if (!st.expired)
						st.frame = 8'd0;
				end
				default: ;
			endcase
			res.frame_index = st.frame;
			res.mode        = st.mode;
			res.expired     = st.expired;
			return res;
		endfunction

		function void note_input(input in_item_t it);
			pending.push_back(predict(it));
		endfunction

		task check_result(input out_item_t got);
			out_item_t exp_item;
			if (pending.size() == 0) begin
				report($sformatf("unexpected item %h", got));
			end else begin
				exp_item = pending.pop_front();
				if (got.frame_index !== exp_item.frame_index)
					report($sformatf("frame_index %0d, want %0d", got.frame_index,
						exp_item.frame_index));
				if (got.mode !== exp_item.mode)
					report($sformatf("mode %0d, want %0d", got.mode, exp_item.mode));
				if (got.expired !== exp_item.expired)
					report($sformatf("expired %b, want %b", got.expired, exp_item.expired));
				if (got.stepped !== exp_item.stepped)
					report($sformatf("stepped %b, want %b", got.stepped, exp_item.stepped));
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	int         gap_pct;
	int         stall_pct;
	int         holdoff_left;

	frame_scoreboard sb = new();

	sfs_in_if  req_ch ();
	sfs_out_if rsp_ch ();

	sprite_frame_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("sprite_frame_sequencer_tb failed");
		$finish;
	end

	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready)
			sb.note_input(req_ch.data);
	end

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready)
			sb.check_result(rsp_ch.data);
	end

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_left > 0) begin
				rsp_ch.ready <= 1'b0;
				holdoff_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task send_item(input in_item_t it);
		while ($urandom_range(99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= it;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task wait_drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_frame_count(input logic [7:0] value);
		wait_drain();
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.frame_count = value;
	endtask

	function in_item_t noise_item();
		in_item_t it;
		it.operation    = OP_TICK;
		it.hold         = 1'b0;
		it.new_mode     = 4'($urandom_range(10));
		it.new_speed    = 8'($urandom_range(255));
		it.random_frame = 8'($urandom_range(254));
		return it;
	endfunction

	task do_tick(input logic hold, input logic [7:0] rnd);
		in_item_t it;
		it = noise_item();
		it.hold = hold;
		it.random_frame = rnd;
		send_item(it);
	endtask

	task do_set(input logic [3:0] m, input logic [7:0] spd);
		in_item_t it;
		it = noise_item();
		it.operation = OP_SET;
		it.new_mode  = m;
		it.new_speed = spd;
		send_item(it);
	endtask

	task do_restart();
		in_item_t it;
		it = noise_item();
		it.operation = OP_RESTART;
		send_item(it);
	endtask

	function in_item_t random_item(input bit allow_die);
		in_item_t it;
		int       r;
		int       s;
		it = noise_item();
		r = $urandom_range(99);
		s = $urandom_range(99);
		it.hold = ($urandom_range(9) == 0);
		if (!allow_die && it.new_mode == MODE_ONCE_DIE)
			it.new_mode = MODE_LOOP;
		if (s < 60)
			it.new_speed = 8'd0;
		else if (s < 90)
			it.new_speed = 8'($urandom_range(3, 1));
		if (r < 75)
			it.operation = OP_TICK;
		else if (r < 90)
			it.operation = OP_SET;
		else
			it.operation = OP_RESTART;
		return it;
	endfunction

	task run_phase(input logic [7:0] count, input int gap, input int stall, input int n,
		input bit allow_die);
		write_frame_count(count);
		gap_pct   = gap;
		stall_pct = stall;
		repeat (n)
			send_item(random_item(allow_die));
	endtask

	initial begin
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= 8'd0;
		gap_pct      = 0;
		stall_pct    = 0;
		holdoff_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		do_tick(1'b0, 8'd0);
		do_tick(1'b1, 8'd0);
		do_set(MODE_TOGGLE, 8'd0);
		do_tick(1'b0, 8'd0);
		do_tick(1'b0, 8'd0);
		do_set(MODE_RANDOM, 8'd0);
		do_tick(1'b0, 8'd254);
		write_frame_count(8'd4);
		do_set(MODE_RANDOM, 8'd0);
		do_tick(1'b0, 8'd2);
		do_tick(1'b0, 8'd254);
		do_set(MODE_ONCE_LAST, 8'd0);
		do_restart();
		repeat (4) do_tick(1'b0, 8'd0);
		do_tick(1'b0, 8'd0);
		do_set(MODE_BACK_ONCE, 8'd1);
		do_tick(1'b0, 8'd0);
		do_tick(1'b0, 8'd0);
		do_set(MODE_PING_FWD, 8'd0);
		do_tick(1'b0, 8'd0);
		do_tick(1'b0, 8'd0);
		do_set(MODE_LOOP_BACK, 8'd0);
		do_restart();
		do_tick(1'b0, 8'd0);
		do_set(MODE_STOP, 8'd255);
		do_tick(1'b0, 8'd0);

		wait_drain();
		holdoff_left = 60;
		run_phase(8'd255, 0, 0, 80, 1'b0);
		run_phase(8'd1, 62, 0, 80, 1'b0);
		run_phase(8'd2, 0, 62, 80, 1'b0);
		run_phase(8'($urandom_range(8, 3)), 25, 25, 80, 1'b0);
		run_phase(8'($urandom_range(255, 1)), 25, 0, 60, 1'b0);

		write_frame_count(8'd3);
		gap_pct   = 25;
		stall_pct = 25;
		do_restart();
		do_set(MODE_ONCE_DIE, 8'd0);
		repeat (3) do_tick(1'b0, 8'd0);
		do_tick(1'b0, 8'd0);
		do_set(MODE_LOOP_BACK, 8'd5);
		do_restart();
		do_tick(1'b0, 8'd0);
		repeat (15) send_item(random_item(1'b1));

		wait_drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("sprite_frame_sequencer_tb passed");
		else
			$display("sprite_frame_sequencer_tb failed");
		$finish;
	end

endmodule
